>>> rtl/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg : shared definitions of the polyphonic feedback delay
// Sizes of the voice space and delay memory, register codes and the
// delay-memory access bundle.
// ----------------------------------------------------------------------------
package pfd_pkg;

   // voice space and per-voice delay region
   localparam int VOICES       = 8;
   localparam int VOICE_W      = $clog2(VOICES);
   localparam int BUFFER_DEPTH = 65536;
   localparam int CUR_W        = $clog2(BUFFER_DEPTH);
   localparam int ADDR_W       = VOICE_W + CUR_W;
   localparam int MEM_DEPTH    = VOICES * BUFFER_DEPTH;

   // audio and gain widths
   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 16;
   localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;

   // register file
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY_LENGTH  = 2'd0,
      CSR_FEEDBACK_GAIN = 2'd1,
      CSR_OUTPUT_GAIN   = 2'd2
   } csr_index_type;

   // delay memory access bundle
   typedef struct packed {
      logic                       rd_en;
      logic [ADDR_W-1:0]          rd_addr;
      logic                       wr_en;
      logic [ADDR_W-1:0]          wr_addr;
      logic signed [SAMPLE_W-1:0] wr_data;
   } ram_req_type;

endpackage

>>> rtl/pfd_if.sv
// ----------------------------------------------------------------------------
// pfd_if : handshake channels of the polyphonic feedback delay
// Sample in, sample out and register write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface pfd_req_if;
   import pfd_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [VOICE_W-1:0]         in_voice;
   logic signed [SAMPLE_W-1:0] in_sample;

   modport source (output valid, output in_voice, output in_sample, input ready);
   modport sink   (input valid, input in_voice, input in_sample, output ready);
endinterface

interface pfd_rsp_if;
   import pfd_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [VOICE_W-1:0]         out_voice;
   logic signed [SAMPLE_W-1:0] out_sample;

   modport source (output valid, output out_voice, output out_sample, input ready);
   modport sink   (input valid, input out_voice, input out_sample, output ready);
endinterface

interface pfd_csr_if;
   import pfd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/polyphonic_feedback_delay.sv
// ----------------------------------------------------------------------------
// polyphonic_feedback_delay : per-voice feedback comb (echo) delay
// Reads the delayed sample at the voice cursor, writes back the input plus
// the feedback-scaled delayed sample and returns the input plus the
// output-scaled delayed sample, both saturated.
// ----------------------------------------------------------------------------
// Takes one sample per clock unless the output stalls or an entry hazard
// holds it, and returns its result after the registered lookup/read, multiply
// and mix/write steps. The hazard comes from the single read-modify-write of
// the delay memory: of two items in a row on the same delay entry (a voice
// with a delay length of 0 or 1 repeated back to back), the second is held
// so that it reaches stage 1 only once the first item's write-back sits in
// the forwarding register. The delay memory is never swept: a per-voice fill
// count marks written entries, and unwritten ones read as zero, so samples
// are taken as soon as reset is released. Register writes are accepted at
// any time but must only be issued while no samples are in flight.
// ----------------------------------------------------------------------------
module polyphonic_feedback_delay (
   input  logic      clock,
   input  logic      reset,
   pfd_req_if.sink   req_in,
   pfd_rsp_if.source rsp_out,
   pfd_csr_if.sink   csr_in
);
   import pfd_pkg::*;

   // round a Q1.15 product, add the sample and saturate to 16 bits
   function automatic logic signed [SAMPLE_W-1:0] mix_sat(
      input logic signed [SAMPLE_W-1:0] x,
      input logic signed [PROD_W-1:0]   p
   );
      logic signed [PROD_W:0] r;
      logic signed [PROD_W:0] s;
      r = $signed({p[PROD_W-1], p}) + (PROD_W+1)'(16384);
      r = r >>> 15;
      s = r + (PROD_W+1)'(x);
      if (s > (PROD_W+1)'(32767)) begin
         return 16'sh7fff;
      end else if (s < -(PROD_W+1)'(32768)) begin
         return 16'sh8000;
      end else begin
         return s[SAMPLE_W-1:0];
      end
   endfunction

   // configuration registers
   logic [CSR_DAT_W-1:0] delay_length_ff;
   logic [GAIN_W-1:0]    feedback_gain_ff;
   logic [GAIN_W-1:0]    output_gain_ff;

   // per-voice cursors and fill counts
   logic [CUR_W-1:0] cursor_ff [VOICES];
   logic [CUR_W-1:0] fill_ff   [VOICES];

   // pipeline stage 1: memory read data arrives
   logic                       s1_valid_ff;
   logic                       s1_live_ff;
   logic [VOICE_W-1:0]         s1_voice_ff;
   logic signed [SAMPLE_W-1:0] s1_x_ff;
   logic [ADDR_W-1:0]          s1_addr_ff;

   // pipeline stage 2: products registered
   logic                       s2_valid_ff;
   logic [VOICE_W-1:0]         s2_voice_ff;
   logic signed [SAMPLE_W-1:0] s2_x_ff;
   logic [ADDR_W-1:0]          s2_addr_ff;
   logic signed [PROD_W-1:0]   s2_pfb_ff;
   logic signed [PROD_W-1:0]   s2_pout_ff;

   // last write-back, forwarded to stage 1
   logic                       s3_valid_ff;
   logic [ADDR_W-1:0]          s3_addr_ff;
   logic signed [SAMPLE_W-1:0] s3_data_ff;

   // output register
   logic                       out_valid_ff;
   logic [VOICE_W-1:0]         out_voice_ff;
   logic signed [SAMPLE_W-1:0] out_sample_ff;

   logic                       advance;
   logic                       hazard;
   logic                       req_fire;
   logic [CUR_W-1:0]           cur_rd;
   logic [CUR_W-1:0]           fill_rd;
   logic [CUR_W-1:0]           len_eff;
   logic [CUR_W:0]             cur_inc;
   logic [CUR_W-1:0]           cursor_in;
   logic [CUR_W-1:0]           fill_in;
   logic [ADDR_W-1:0]          addr_in;
   logic signed [SAMPLE_W-1:0] ram_rd_data;
   logic signed [SAMPLE_W-1:0] delayed;
   logic signed [SAMPLE_W-1:0] wb_data;
   logic signed [SAMPLE_W-1:0] mix_data;
   ram_req_type                ram_req;

   // register writes, always taken
   assign csr_in.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_length_ff  <= CSR_DAT_W'(32767);
         feedback_gain_ff <= GAIN_W'(16384);
         output_gain_ff   <= GAIN_W'(16384);
      end else if (csr_in.valid) begin
         unique case (csr_index_type'(csr_in.index))
            CSR_DELAY_LENGTH:  delay_length_ff  <= csr_in.data;
            CSR_FEEDBACK_GAIN: feedback_gain_ff <= csr_in.data;
            CSR_OUTPUT_GAIN:   output_gain_ff   <= csr_in.data;
            default: ;
         endcase
      end
   end

   // whole pipeline moves when the output register can take an item
   assign advance = !out_valid_ff || rsp_out.ready;

   // cursor lookup and next cursor
   assign cur_rd  = cursor_ff[req_in.in_voice];
   assign fill_rd = fill_ff[req_in.in_voice];
   assign addr_in = {req_in.in_voice, cur_rd};
   assign len_eff = (delay_length_ff == '0) ? CUR_W'(1) : delay_length_ff;
   assign cur_inc = {1'b0, cur_rd} + (CUR_W+1)'(1);

   always_comb begin
      cursor_in = (cur_inc >= {1'b0, len_eff}) ? '0 : cur_inc[CUR_W-1:0];
      fill_in   = (cur_rd == fill_rd) ? cur_inc[CUR_W-1:0] : fill_rd;
   end

   // interlock: the item ahead has not yet written this entry
   assign hazard       = s1_valid_ff && (s1_addr_ff == addr_in);
   assign req_in.ready = advance && !hazard;
   assign req_fire     = req_in.valid && req_in.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < VOICES; v++) begin
            cursor_ff[v] <= '0;
            fill_ff[v]   <= '0;
         end
      end else if (req_fire) begin
         cursor_ff[req_in.in_voice] <= cursor_in;
         fill_ff[req_in.in_voice]   <= fill_in;
      end
   end

   // delay memory
   always_comb begin
      ram_req.rd_en   = advance;
      ram_req.rd_addr = addr_in;
      ram_req.wr_en   = advance && s2_valid_ff;
      ram_req.wr_addr = s2_addr_ff;
      ram_req.wr_data = wb_data;
   end

   pfd_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   // stage 1 control and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_live_ff  <= cur_rd < fill_rd;
         s1_voice_ff <= req_in.in_voice;
         s1_x_ff     <= req_in.in_sample;
         s1_addr_ff  <= addr_in;
      end
   end

   // delayed sample: zero if never written, else forwarded or read
   always_comb begin
      if (!s1_live_ff) begin
         delayed = '0;
      end else if (s3_valid_ff && (s3_addr_ff == s1_addr_ff)) begin
         delayed = s3_data_ff;
      end else begin
         delayed = ram_rd_data;
      end
   end

   // stage 2: gain products
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_voice_ff <= s1_voice_ff;
         s2_x_ff     <= s1_x_ff;
         s2_addr_ff  <= s1_addr_ff;
         s2_pfb_ff   <= delayed * $signed({1'b0, feedback_gain_ff});
         s2_pout_ff  <= delayed * $signed({1'b0, output_gain_ff});
      end
   end

   // stage 2: round, mix, saturate
   assign wb_data  = mix_sat(s2_x_ff, s2_pfb_ff);
   assign mix_data = mix_sat(s2_x_ff, s2_pout_ff);

   // forwarding register for the write landing with the next read
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_addr_ff <= s2_addr_ff;
         s3_data_ff <= wb_data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_voice_ff  <= s2_voice_ff;
         out_sample_ff <= mix_data;
      end
   end

   assign rsp_out.valid      = out_valid_ff;
   assign rsp_out.out_voice  = out_voice_ff;
   assign rsp_out.out_sample = out_sample_ff;

   // checks
   a_no_adjacent_same_entry: assert property (
      @(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff) |-> (s1_addr_ff != s2_addr_ff))
      else $error("two adjacent items on one delay entry");

   a_cursor_within_fill: assert property (
      @(posedge clock) disable iff (reset)
      req_fire |-> (cur_rd <= fill_rd))
      else $error("cursor ahead of fill count");

   a_write_forwarded: assert property (
      @(posedge clock) disable iff (reset)
      (advance && s2_valid_ff) |=> (s3_valid_ff && s3_addr_ff == $past(s2_addr_ff)))
      else $error("write-back not held for forwarding");

endmodule

>>> rtl/pfd_ram.sv
// ----------------------------------------------------------------------------
// pfd_ram : delay memory
// Single-clock memory, one write and one read port, registered read data.
// A read and a write to the same entry in one cycle return the old contents.
// ----------------------------------------------------------------------------
module pfd_ram (
   input  logic                                clock,
   input  pfd_pkg::ram_req_type                ram_req,
   output logic signed [pfd_pkg::SAMPLE_W-1:0] rd_data
);
   import pfd_pkg::*;

   logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // read port, held while not enabled
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
